### design/sshg_pkg.sv
// Shared types, constants and controller states for the Shell sort block.
package sshg_pkg;

    localparam int MAX_ITEMS_DEF = 64;
    localparam int DATA_W        = 32;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last_item;
    } t_req;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     last_result;
        logic                     overflowed;
    } t_res;

    typedef enum logic [3:0] {
        S_LOAD,
        S_SORT_INIT,
        S_GAP,
        S_POS_RD,
        S_POS_WAIT,
        S_CMP_RD,
        S_CMP_WAIT,
        S_PUT,
        S_OUT_RD,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic gap_init;
        logic gap_halve;
        logic pass_start;
        logic pos_rd;
        logic held_ld;
        logic cmp_rd;
        logic shift;
        logic put;
        logic out_rd;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic gap_zero;
        logic pos_lt_n;
        logic slot_ge_gap;
        logic greater;
        logic idx_last;
    } t_status;

endpackage

### design/sshg_ram.sv
// Generic simple dual-port RAM with registered read.
module sshg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/sshg_dp.sv
// Datapath: element store, count, gap, position and slot registers, compare.
module sshg_dp import sshg_pkg::*; #(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    input  t_req    i_req,
    output t_status o_status,
    output t_res    o_res
);

    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int AW = $clog2(MAX_ITEMS);

    logic [CW-1:0]     r_count, n_count;
    logic              r_ovf, n_ovf;
    logic [CW-1:0]     r_gap, n_gap;
    logic [CW-1:0]     r_pos, n_pos;
    logic [CW-1:0]     r_slot, n_slot;
    logic [CW-1:0]     r_idx, n_idx;
    logic [DATA_W-1:0] r_held, n_held;

    logic              full;
    logic [CW-1:0]     slot_back;
    logic [CW-1:0]     idx_inc;
    logic              we;
    logic [AW-1:0]     waddr;
    logic [DATA_W-1:0] wdata;
    logic [AW-1:0]     raddr;
    logic [DATA_W-1:0] rdata;

    assign full      = (r_count == CW'(MAX_ITEMS));
    assign slot_back = r_slot - r_gap;
    assign idx_inc   = r_idx + CW'(1);

    // Memory port steering.
    always_comb begin
        we    = (i_cmd.load && !full) || i_cmd.shift || i_cmd.put;
        waddr = i_cmd.load ? r_count[AW-1:0] : r_slot[AW-1:0];
        if (i_cmd.load) begin
            wdata = i_req.value;
        end else if (i_cmd.shift) begin
            wdata = rdata;
        end else begin
            wdata = r_held;
        end
        if (i_cmd.pos_rd) begin
            raddr = r_pos[AW-1:0];
        end else if (i_cmd.cmp_rd) begin
            raddr = slot_back[AW-1:0];
        end else if (i_cmd.emit) begin
            raddr = idx_inc[AW-1:0];
        end else begin
            raddr = r_idx[AW-1:0];
        end
    end

    sshg_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        n_count = r_count;
        n_ovf   = r_ovf;
        n_gap   = r_gap;
        n_pos   = r_pos;
        n_slot  = r_slot;
        n_idx   = r_idx;
        n_held  = r_held;
        if (i_cmd.load) begin
            if (full) begin
                n_ovf = 1'b1;
            end else begin
                n_count = r_count + CW'(1);
            end
        end
        if (i_cmd.gap_init) begin
            n_gap = r_count >> 1;
            n_idx = '0;
        end
        if (i_cmd.gap_halve) begin
            n_gap = r_gap >> 1;
        end
        if (i_cmd.pass_start) begin
            n_pos = r_gap;
        end
        if (i_cmd.pos_rd) begin
            n_slot = r_pos;
        end
        if (i_cmd.held_ld) begin
            n_held = rdata;
        end
        if (i_cmd.shift) begin
            n_slot = slot_back;
        end
        if (i_cmd.put) begin
            n_pos = r_pos + CW'(1);
        end
        if (i_cmd.emit) begin
            n_idx = idx_inc;
            // Close the set on its final result.
            if (idx_inc == r_count) begin
                n_count = '0;
                n_ovf   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_gap  <= n_gap;
        r_pos  <= n_pos;
        r_slot <= n_slot;
        r_idx  <= n_idx;
        r_held <= n_held;
    end

    assign o_status.gap_zero    = (r_gap == '0);
    assign o_status.pos_lt_n    = (r_pos < r_count);
    assign o_status.slot_ge_gap = (r_slot >= r_gap);
    assign o_status.greater     = ($signed(rdata) > $signed(r_held));
    assign o_status.idx_last    = (idx_inc == r_count);

    assign o_res.sorted_value = rdata;
    assign o_res.last_result  = (idx_inc == r_count);
    assign o_res.overflowed   = r_ovf;

endmodule

### design/sshg_ctrl.sv
// Controller: load, gapped insertion passes and result sequencing.
module sshg_ctrl import sshg_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_last,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy,
    output logic    o_strobe
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (i_start && i_last) begin
                    n_state = S_SORT_INIT;
                end
            end
            S_SORT_INIT: n_state = S_GAP;
            S_GAP: begin
                n_state = i_status.gap_zero ? S_OUT_RD : S_POS_RD;
            end
            S_POS_RD: begin
                n_state = i_status.pos_lt_n ? S_POS_WAIT : S_GAP;
            end
            S_POS_WAIT: n_state = S_CMP_RD;
            S_CMP_RD: begin
                n_state = i_status.slot_ge_gap ? S_CMP_WAIT : S_PUT;
            end
            S_CMP_WAIT: begin
                n_state = i_status.greater ? S_CMP_RD : S_PUT;
            end
            S_PUT:    n_state = S_POS_RD;
            S_OUT_RD: n_state = S_OUT;
            S_OUT: begin
                if (i_status.idx_last) begin
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_comb begin
        o_cmd    = '0;
        o_busy   = 1'b1;
        o_strobe = 1'b0;
        case (r_state)
            S_LOAD: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            S_SORT_INIT: o_cmd.gap_init = 1'b1;
            S_GAP: begin
                o_cmd.pass_start = !i_status.gap_zero;
                o_cmd.out_rd     = i_status.gap_zero;
            end
            S_POS_RD: begin
                o_cmd.pos_rd    = i_status.pos_lt_n;
                o_cmd.gap_halve = !i_status.pos_lt_n;
            end
            S_POS_WAIT: o_cmd.held_ld = 1'b1;
            S_CMP_RD:   o_cmd.cmp_rd  = i_status.slot_ge_gap;
            S_CMP_WAIT: o_cmd.shift   = i_status.greater;
            S_PUT:      o_cmd.put     = 1'b1;
            S_OUT_RD:   o_cmd.out_rd  = 1'b1;
            S_OUT: begin
                o_cmd.emit = 1'b1;
                o_strobe   = 1'b1;
            end
            default: o_busy = 1'b1;
        endcase
    end

endmodule

### design/shell_sort_halving_gaps_core.sv
// Top level of the Shell sort block with the halving gap sequence.
//
//  channel   direction  handshake                 payload
//  request   in         start high, busy low      i_req (t_req)
//  result    out        o_strobe, one cycle       o_res (t_res)
//
// Requests load one per cycle into a single-port-write store while busy is low.
// The closing request raises busy; each gap starts a pass, and each position in a pass
// reads its element, then compares and shifts elements down its chain, all through the
// one store read port; results follow at one per cycle after a read start.
// Reset clears count, overflow flag and controller; the store needs no clearing.
// Results cannot be held off; busy stays high until the final one is out.
module shell_sort_halving_gaps_core import sshg_pkg::*; #(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_strobe,
    output t_res o_res
);

    t_cmd    cmd;
    t_status status;

    sshg_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_last   (i_req.last_item),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_strobe (o_strobe)
    );

    sshg_dp #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_req    (i_req),
        .o_status (status),
        .o_res    (o_res)
    );

endmodule

### design/sshg_checker.sv
// Port-level checker for the Shell sort block, bound to the top level.
module sshg_checker import sshg_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input t_req i_req,
    input logic o_strobe,
    input t_res o_res
);

    // A result only appears while the block is busy.
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result strobe while not busy");

    // Closing request starts the sort.
    a_close_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.last_item) |=> busy)
        else $error("closing request did not raise busy");

    // Other requests leave the block ready.
    a_load_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_req.last_item) |=> !busy)
        else $error("plain request raised busy");

    // Results of a set come back to back until the final one.
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_res.last_result) |=> o_strobe)
        else $error("gap in result burst");

    // After the final result the block is ready again.
    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.last_result) |=> (!busy && !o_strobe))
        else $error("block not released after final result");

endmodule

bind shell_sort_halving_gaps_core sshg_checker u_sshg_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_req    (i_req),
    .o_strobe (o_strobe),
    .o_res    (o_res)
);

### tb/tb_shell_sort_halving_gaps_core.sv
// Self-checking testbench for the Shell sort block: random sets against a scoreboard.

class sort_scoreboard;
    logic signed [31:0]  open_set[$];
    bit                  set_dropped;
    sshg_pkg::t_res      sorted_expected[$];
    int                  mismatches;
    int                  results_checked;
    int                  sets_closed;
    int                  overflow_sets;
    int                  largest_set;

    function new();
        set_dropped     = 1'b0;
        mismatches      = 0;
        results_checked = 0;
        sets_closed     = 0;
        overflow_sets   = 0;
        largest_set     = 0;
    endfunction

    task report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40) $display("MISMATCH: %s", msg);
    endtask

    // Gapped insertion with gaps n/2, n/4 .. 1 over the set held so far.
    function void sort_open_set();
        int                 n;
        int                 gap;
        int                 pos;
        int                 slot;
        logic signed [31:0] held;
        n = open_set.size();
        for (gap = n / 2; gap > 0; gap = gap / 2) begin
            for (pos = gap; pos < n; pos++) begin
                held = open_set[pos];
                slot = pos;
                while (slot >= gap && open_set[slot - gap] > held) begin
                    open_set[slot] = open_set[slot - gap];
                    slot = slot - gap;
                end
                open_set[slot] = held;
            end
        end
    endfunction

    function void note_request(input sshg_pkg::t_req req);
        sshg_pkg::t_res res;
        int             n;
        if (open_set.size() < sshg_pkg::MAX_ITEMS_DEF) open_set.push_back(req.value);
        else set_dropped = 1'b1;
        if (!req.last_item) return;
        sort_open_set();
        n = open_set.size();
        for (int k = 0; k < n; k++) begin
            res.sorted_value = open_set[k];
            res.last_result  = (k == n - 1);
            res.overflowed   = set_dropped;
            sorted_expected.push_back(res);
        end
        sets_closed++;
        if (set_dropped) overflow_sets++;
        if (n > largest_set) largest_set = n;
        open_set.delete();
        set_dropped = 1'b0;
    endfunction

    task check_result(input sshg_pkg::t_res got);
        sshg_pkg::t_res want;
        results_checked++;
        if (sorted_expected.size() == 0) begin
            report_mismatch($sformatf("unexpected result value=%0d last=%0b ovf=%0b",
                                      got.sorted_value, got.last_result, got.overflowed));
            return;
        end
        want = sorted_expected.pop_front();
        if (got.sorted_value !== want.sorted_value)
            report_mismatch($sformatf("sorted_value got %0d want %0d",
                                      got.sorted_value, want.sorted_value));
        if (got.last_result !== want.last_result)
            report_mismatch($sformatf("last_result got %0b want %0b",
                                      got.last_result, want.last_result));
        if (got.overflowed !== want.overflowed)
            report_mismatch($sformatf("overflowed got %0b want %0b",
                                      got.overflowed, want.overflowed));
    endtask
endclass

module tb_shell_sort_halving_gaps_core;
    import sshg_pkg::*;

    localparam int ITEM_TARGET = 410;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 20;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_req i_req;
    logic o_strobe;
    t_res o_res;

    sort_scoreboard sb;
    int             cycle_count;
    int             items_sent;

    shell_sort_halving_gaps_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_strobe(o_strobe),
        .o_res   (o_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_shell_sort_halving_gaps_core: FAIL");
            $finish;
        end
    end

    // Results cannot be held off: take each one on the edge that ends its cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) sb.check_result(o_res);
    end

    // Hold start low through a random gap, then present the request until busy is low.
    task send_request(input logic signed [31:0] value, input logic last);
        int   gap;
        t_req req;
        gap = $urandom_range(0, 10);
        req.value     = value;
        req.last_item = last;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= req;
        do @(posedge i_clk); while (busy);
        sb.note_request(req);
        items_sent++;
    endtask

    task send_set(input int size, input int mode);
        logic signed [31:0] v;
        logic signed [31:0] walk;
        walk = $urandom_range(0, 2000) - 1000;
        for (int k = 0; k < size; k++) begin
            case (mode)
                0: v = $urandom;
                1: v = $urandom_range(0, 8) - 4;
                2: begin
                    case ($urandom_range(0, 4))
                        0: v = 32'sh8000_0000;
                        1: v = 32'sh7fff_ffff;
                        2: v = -1;
                        3: v = 0;
                        default: v = 1;
                    endcase
                end
                3: begin
                    walk = walk + $urandom_range(0, 50);
                    v = walk;
                end
                default: begin
                    walk = walk - $urandom_range(0, 50);
                    v = walk;
                end
            endcase
            send_request(v, k == size - 1);
        end
    endtask

    initial begin
        int size;
        int pick;
        int set_no;
        int waited;
        sb          = new();
        cycle_count = 0;
        items_sent  = 0;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_req   <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Single-element sets at both extremes, then mixed extremes, duplicates and orderings.
        send_request(32'sh8000_0000, 1'b1);
        send_request(32'sh7fff_ffff, 1'b1);
        send_request(32'sh7fff_ffff, 1'b0);
        send_request(32'sh8000_0000, 1'b1);
        send_request(32'sh7fff_ffff, 1'b0);
        send_request(-1, 1'b0);
        send_request(0, 1'b0);
        send_request(32'sh8000_0000, 1'b0);
        send_request(1, 1'b1);
        send_request(5, 1'b0);
        send_request(5, 1'b0);
        send_request(5, 1'b1);
        send_request(-3, 1'b0);
        send_request(3, 1'b0);
        send_request(-3, 1'b0);
        send_request(3, 1'b1);
        send_set(6, 3);
        send_set(7, 4);

        // Random sets; a full store, a closing request that finds it full, and a long overflow.
        set_no = 0;
        while (items_sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (set_no == 2) size = MAX_ITEMS_DEF;
            else if (set_no == 4) size = MAX_ITEMS_DEF + 1;
            else if (set_no == 7) size = MAX_ITEMS_DEF + 6;
            else if (pick < 70) size = $urandom_range(1, 12);
            else if (pick < 85) size = $urandom_range(13, 32);
            else if (pick < 93) size = $urandom_range(33, MAX_ITEMS_DEF);
            else size = $urandom_range(MAX_ITEMS_DEF + 1, MAX_ITEMS_DEF + 8);
            send_set(size, $urandom_range(0, 4));
            set_no++;
        end
        start <= 1'b0;

        waited = 0;
        while (sb.sorted_expected.size() != 0) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d requests in %0d sets (%0d with dropped elements, largest %0d)",
                 items_sent, sb.sets_closed, sb.overflow_sets, sb.largest_set);
        $display("checked %0d sorted results, %0d mismatches", sb.results_checked,
                 sb.mismatches);
        if (sb.mismatches == 0 && sb.sorted_expected.size() == 0) begin
            $display("tb_shell_sort_halving_gaps_core: PASS");
        end else begin
            $display("tb_shell_sort_halving_gaps_core: FAIL");
        end
        $finish;
    end
endmodule
